// ===== sv/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

    localparam int TIME_WIDTH_DEF = 10;
    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_W      = 3;
    localparam int BYTE_W         = 8;
    localparam int BIT_IDX_W      = 3;

    // Power-on timing values, in ticks.
    localparam int RESET_LOW_DEF   = 480;
    localparam int PRES_SAMPLE_DEF = 70;
    localparam int RESET_TAIL_DEF  = 410;
    localparam int SHORT_LOW_DEF   = 6;
    localparam int LONG_LOW_DEF    = 60;
    localparam int READ_SAMPLE_DEF = 15;
    localparam int SLOT_DEF        = 70;

    localparam logic [BIT_IDX_W-1:0] BIT_LAST = BIT_IDX_W'(BYTE_W - 1);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_SLOT     = 3'd4
    } phase_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_SAMPLE = 3'd1,
        REG_RESET_TAIL  = 3'd2,
        REG_SHORT_LOW   = 3'd3,
        REG_LONG_LOW    = 3'd4,
        REG_READ_SAMPLE = 3'd5,
        REG_SLOT        = 3'd6
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== sv/owm_if.sv =====
// ----------------------------------------------------------------------------
// owm_if
// Command and result channels of the single-wire bus master.
// ----------------------------------------------------------------------------
`default_nettype none

interface owm_cmd_if;
    import owm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [BYTE_W-1:0]   data;
    logic                line_in;

    modport source (output valid, output func, output data, output line_in, input ready);
    modport sink   (input valid, input func, input data, input line_in, output ready);
endinterface

interface owm_rsp_if;
    import owm_pkg::*;

    logic                valid;
    logic                ready;
    logic                line_low;
    logic                busy_res;
    logic                done_res;
    logic                presence;
    logic [BYTE_W-1:0]   read_data;
    logic                rejected;

    modport source (output valid, output line_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink   (input valid, input line_low, input busy_res, input done_res,
                    input presence, input read_data, input rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/owm_cfg.sv =====
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file with the clamped limits used by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module owm_cfg #(
    parameter int TIME_WIDTH = owm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [owm_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [TIME_WIDTH-1:0]          cfg_data,
    output logic      [TIME_WIDTH-1:0]          lim_rst_low,
    output logic      [TIME_WIDTH-1:0]          lim_rst_wait,
    output logic      [TIME_WIDTH-1:0]          lim_rst_tail,
    output logic      [TIME_WIDTH-1:0]          low_short,
    output logic      [TIME_WIDTH-1:0]          low_long,
    output logic      [TIME_WIDTH-1:0]          sample_at,
    output logic      [TIME_WIDTH-1:0]          slot_last
);
    import owm_pkg::*;

    localparam logic [TIME_WIDTH-1:0] ONE = TIME_WIDTH'(1);
    localparam logic [TIME_WIDTH-1:0] TWO = TIME_WIDTH'(2);

    logic [TIME_WIDTH-1:0] rst_low_reg;
    logic [TIME_WIDTH-1:0] pres_sample_reg;
    logic [TIME_WIDTH-1:0] rst_tail_reg;
    logic [TIME_WIDTH-1:0] short_low_reg;
    logic [TIME_WIDTH-1:0] long_low_reg;
    logic [TIME_WIDTH-1:0] read_sample_reg;
    logic [TIME_WIDTH-1:0] slot_reg;
    logic [TIME_WIDTH-1:0] slot_eff;
    logic [TIME_WIDTH-1:0] sample_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_low_reg     <= TIME_WIDTH'(RESET_LOW_DEF);
            pres_sample_reg <= TIME_WIDTH'(PRES_SAMPLE_DEF);
            rst_tail_reg    <= TIME_WIDTH'(RESET_TAIL_DEF);
            short_low_reg   <= TIME_WIDTH'(SHORT_LOW_DEF);
            long_low_reg    <= TIME_WIDTH'(LONG_LOW_DEF);
            read_sample_reg <= TIME_WIDTH'(READ_SAMPLE_DEF);
            slot_reg        <= TIME_WIDTH'(SLOT_DEF);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RESET_LOW:   rst_low_reg     <= cfg_data;
                REG_PRES_SAMPLE: pres_sample_reg <= cfg_data;
                REG_RESET_TAIL:  rst_tail_reg    <= cfg_data;
                REG_SHORT_LOW:   short_low_reg   <= cfg_data;
                REG_LONG_LOW:    long_low_reg    <= cfg_data;
                REG_READ_SAMPLE: read_sample_reg <= cfg_data;
                REG_SLOT:        slot_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A zero time counts as one tick; the slot is at least two ticks long.
    assign lim_rst_low  = (rst_low_reg == '0)     ? '0 : rst_low_reg - ONE;
    assign lim_rst_wait = (pres_sample_reg == '0) ? '0 : pres_sample_reg - ONE;
    assign lim_rst_tail = (rst_tail_reg == '0)    ? '0 : rst_tail_reg - ONE;
    assign low_short    = (short_low_reg == '0)   ? ONE : short_low_reg;
    assign low_long     = (long_low_reg == '0)    ? ONE : long_low_reg;
    assign slot_eff     = (slot_reg < TWO)        ? TWO : slot_reg;
    assign slot_last    = slot_eff - ONE;
    assign sample_eff   = (read_sample_reg == '0) ? ONE : read_sample_reg;

    // A sample point past the slot end falls on the last tick of the slot.
    assign sample_at    = (sample_eff > slot_last) ? slot_last : sample_eff;

endmodule

`default_nettype wire

// ===== sv/one_wire_bus_master.sv =====
// Result: registered, and presented in the cycle after its command beat is accepted.
// Throughput: one beat per cycle; the result register and the bus state update
// in the same cycle, so a new beat is taken whenever the result slot is free or
// being drained. Reset: sequencer idle, presence and read byte cleared, timing
// registers at their power-on values, no result pending.
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-driven single-wire bus master for reset/presence, byte write and read.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master #(
    parameter int TIME_WIDTH = owm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    owm_cmd_if.sink                             cmd,
    owm_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [owm_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [TIME_WIDTH-1:0]          cfg_data
);
    import owm_pkg::*;

    logic [TIME_WIDTH-1:0] lim_rst_low;
    logic [TIME_WIDTH-1:0] lim_rst_wait;
    logic [TIME_WIDTH-1:0] lim_rst_tail;
    logic [TIME_WIDTH-1:0] low_short;
    logic [TIME_WIDTH-1:0] low_long;
    logic [TIME_WIDTH-1:0] sample_at;
    logic [TIME_WIDTH-1:0] slot_last;

    owm_cfg #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .lim_rst_low  (lim_rst_low),
        .lim_rst_wait (lim_rst_wait),
        .lim_rst_tail (lim_rst_tail),
        .low_short    (low_short),
        .low_long     (low_long),
        .sample_at    (sample_at),
        .slot_last    (slot_last)
    );

    // Sequencer state.
    phase_t                 phase_reg,    phase_next;
    op_t                    op_reg,       op_next;
    logic [BYTE_W-1:0]      shift_reg,    shift_next;
    logic [BIT_IDX_W-1:0]   bit_reg,      bit_next;
    logic [TIME_WIDTH-1:0]  time_reg,     time_next;
    logic                   presence_reg, presence_next;
    logic [BYTE_W-1:0]      last_read_reg, last_read_next;

    // Result register.
    logic                   rsp_valid_reg;
    logic                   line_low_reg, line_low_next;
    logic                   busy_reg,     busy_next;
    logic                   done_reg,     done_next;
    logic                   rejected_reg, rejected_next;

    logic                   accept;
    logic                   start;
    phase_t                 cur_phase;
    op_t                    cur_op;
    logic [BYTE_W-1:0]      cur_shift;
    logic [BIT_IDX_W-1:0]   cur_bit;
    logic [TIME_WIDTH-1:0]  cur_time;
    logic [TIME_WIDTH-1:0]  time_inc;
    logic [TIME_WIDTH-1:0]  low_time;
    logic [BYTE_W-1:0]      shift_sampled;
    logic                   do_sample;
    logic                   slot_end;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    // A command taken while idle is processed as its own first tick.
    assign start     = (phase_reg == PH_IDLE) && (op_t'(cmd.func) != OP_TICK);
    assign cur_op    = start ? op_t'(cmd.func) : op_reg;
    assign cur_time  = start ? '0 : time_reg;
    assign cur_bit   = start ? '0 : bit_reg;
    assign time_inc  = cur_time + 1'b1;

    always_comb
    begin
        if (!start)
            cur_phase = phase_reg;
        else if (op_t'(cmd.func) == OP_RESET)
            cur_phase = PH_RST_LOW;
        else
            cur_phase = PH_SLOT;
    end

    always_comb
    begin
        if (!start)
            cur_shift = shift_reg;
        else if (op_t'(cmd.func) == OP_WRITE)
            cur_shift = cmd.data;
        else
            cur_shift = '0;
    end

    assign low_time      = (cur_op == OP_WRITE && !cur_shift[0]) ? low_long : low_short;
    assign do_sample     = (cur_op == OP_READ) && (cur_time == sample_at);
    assign shift_sampled = do_sample ? {cmd.line_in, cur_shift[BYTE_W-1:1]} : cur_shift;
    assign slot_end      = (cur_time >= slot_last);

    // Next state of the sequencer.
    always_comb
    begin
        phase_next     = cur_phase;
        op_next        = cur_op;
        shift_next     = cur_shift;
        bit_next       = cur_bit;
        time_next      = time_inc;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        unique case (cur_phase)
            PH_IDLE:
            begin
                time_next = time_reg;
            end
            PH_RST_LOW:
            begin
                if (cur_time >= lim_rst_low)
                begin
                    phase_next = PH_RST_WAIT;
                    time_next  = '0;
                end
            end
            PH_RST_WAIT:
            begin
                if (cur_time >= lim_rst_wait)
                begin
                    phase_next = PH_RST_TAIL;
                    time_next  = '0;
                end
            end
            PH_RST_TAIL:
            begin
                // The bus is sampled on the first tail tick; low means a device answered.
                if (cur_time == '0)
                    presence_next = !cmd.line_in;
                if (cur_time >= lim_rst_tail)
                begin
                    phase_next = PH_IDLE;
                    time_next  = '0;
                end
            end
            PH_SLOT:
            begin
                shift_next = shift_sampled;
                if (slot_end)
                begin
                    if (cur_op == OP_WRITE)
                        shift_next = {1'b0, shift_sampled[BYTE_W-1:1]};
                    if (cur_bit == BIT_LAST)
                    begin
                        if (cur_op == OP_READ)
                            last_read_next = shift_sampled;
                        phase_next = PH_IDLE;
                    end
                    bit_next  = cur_bit + 1'b1;
                    time_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Result of this tick.
    always_comb
    begin
        line_low_next = 1'b0;
        done_next     = 1'b0;
        busy_next     = (cur_phase != PH_IDLE);
        rejected_next = (phase_reg != PH_IDLE) && (op_t'(cmd.func) != OP_TICK);
        unique case (cur_phase)
            PH_IDLE:     ;
            PH_RST_LOW:  line_low_next = 1'b1;
            PH_RST_WAIT: ;
            PH_RST_TAIL: done_next = (cur_time >= lim_rst_tail);
            PH_SLOT:
            begin
                line_low_next = (cur_time < low_time);
                done_next     = slot_end && (cur_bit == BIT_LAST);
            end
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            op_reg        <= OP_TICK;
            shift_reg     <= '0;
            bit_reg       <= '0;
            time_reg      <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            shift_reg     <= shift_next;
            bit_reg       <= bit_next;
            time_reg      <= time_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (accept)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_low_reg <= line_low_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            rejected_reg <= rejected_next;
        end
    end

    // The held status only changes when a new beat loads the result register,
    // so it is driven straight from the sequencer state.
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.line_low  = line_low_reg;
    assign rsp.busy_res  = busy_reg;
    assign rsp.done_res  = done_reg;
    assign rsp.presence  = presence_reg;
    assign rsp.read_data = last_read_reg;
    assign rsp.rejected  = rejected_reg;

endmodule

`default_nettype wire
